[rtl/matrix4x4_row_multiply_assert.svh]
// Assertion macros for the 4x4 row multiplier.
// Used by the top level; needs nothing else.
`ifndef MATRIX4X4_ROW_MULTIPLY_ASSERT_SVH
`define MATRIX4X4_ROW_MULTIPLY_ASSERT_SVH

// same-cycle implication
`define M4RM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define M4RM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/m4rm_pkg.sv]
// Shared widths, types and codes of the 4x4 row multiplier.
// No dependencies.
`default_nettype none

package m4rm_pkg;

    localparam int unsigned N      = 4;
    localparam int unsigned ELEM_W = 32;
    localparam int unsigned ROW_W  = 2;
    localparam int unsigned PROD_W = 2 * ELEM_W;
    localparam int unsigned PAIR_W = PROD_W + 1;
    localparam int unsigned SUM_W  = PROD_W + 2;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_MUL  = 1'b1;

    localparam logic [ELEM_W-1:0] Q_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic [ELEM_W-1:0] Q_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef t_elem [N-1:0]            t_row;
    typedef t_row [N-1:0]             t_mat;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef t_prod [N-1:0]            t_prod_row;
    typedef t_prod_row [N-1:0]        t_prod_mat;
    typedef logic signed [PAIR_W-1:0] t_pair;
    typedef t_pair [1:0]              t_pair_row;
    typedef t_pair_row [N-1:0]        t_pair_mat;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef t_sum [N-1:0]             t_sum_row;

endpackage

`default_nettype wire

[rtl/m4rm_req_if.sv]
// Request channel: load or multiply beat carrying one matrix row.
// Depends on m4rm_pkg.
`default_nettype none

interface m4rm_req_if;
    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic [m4rm_pkg::ROW_W-1:0]          row_index;
    logic signed [m4rm_pkg::ELEM_W-1:0]  elem0;
    logic signed [m4rm_pkg::ELEM_W-1:0]  elem1;
    logic signed [m4rm_pkg::ELEM_W-1:0]  elem2;
    logic signed [m4rm_pkg::ELEM_W-1:0]  elem3;

    modport source (output valid, req_type, row_index, elem0, elem1, elem2, elem3,
                    input ready);
    modport sink   (input valid, req_type, row_index, elem0, elem1, elem2, elem3,
                    output ready);
endinterface

`default_nettype wire

[rtl/m4rm_res_if.sv]
// Result channel: one product row and its clamp flag per beat.
// Depends on m4rm_pkg.
`default_nettype none

interface m4rm_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [m4rm_pkg::ELEM_W-1:0]  prod0;
    logic signed [m4rm_pkg::ELEM_W-1:0]  prod1;
    logic signed [m4rm_pkg::ELEM_W-1:0]  prod2;
    logic signed [m4rm_pkg::ELEM_W-1:0]  prod3;
    logic                                saturated;

    modport source (output valid, prod0, prod1, prod2, prod3, saturated, input ready);
    modport sink   (input valid, prod0, prod1, prod2, prod3, saturated, output ready);
endinterface

`default_nettype wire

[rtl/m4rm_store.sv]
// Right-hand matrix store: sixteen words, written one row per load beat.
// Depends on m4rm_pkg.
`default_nettype none

module m4rm_store (
    input  wire logic                       i_clk,
    input  wire logic                       i_wr_en,
    input  wire logic [m4rm_pkg::ROW_W-1:0] i_wr_row,
    input  wire m4rm_pkg::t_row             i_wr_data,
    output m4rm_pkg::t_mat                  o_mat
);

    m4rm_pkg::t_mat r_mat;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mat[i_wr_row] <= i_wr_data;
        end
    end

    assign o_mat = r_mat;

endmodule

`default_nettype wire

[rtl/m4rm_mult.sv]
// Stages 1 and 2: capture the left row, then form all sixteen products.
// Depends on m4rm_pkg.
`default_nettype none

module m4rm_mult (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire m4rm_pkg::t_row     i_row,
    output logic                    o_ready,
    input  wire m4rm_pkg::t_mat     i_mat,
    output logic                    o_valid,
    output m4rm_pkg::t_prod_mat     o_prod,
    input  wire logic               i_ready
);

    logic                r_v1;
    logic                r_v2;
    m4rm_pkg::t_row      r_a;
    m4rm_pkg::t_prod_mat r_p;
    logic                adv1;
    logic                adv2;

    assign adv2    = !r_v2 || i_ready;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_valid) begin
            r_a <= i_row;
        end
    end

    // column j, term k: a[k] * right[k][j]
    always_ff @(posedge i_clk) begin
        if (adv2 && r_v1) begin
            for (int j = 0; j < m4rm_pkg::N; j++) begin
                for (int k = 0; k < m4rm_pkg::N; k++) begin
                    r_p[j][k] <= $signed(r_a[k]) * $signed(i_mat[k][j]);
                end
            end
        end
    end

    assign o_valid = r_v2;
    assign o_prod  = r_p;

endmodule

`default_nettype wire

[rtl/m4rm_sum.sv]
// Stages 3 and 4: add product pairs, then the two pair sums per column.
// Depends on m4rm_pkg.
`default_nettype none

module m4rm_sum (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire m4rm_pkg::t_prod_mat i_prod,
    output logic                    o_ready,
    output logic                    o_valid,
    output m4rm_pkg::t_sum_row      o_sum,
    input  wire logic               i_ready
);

    logic                r_v3;
    logic                r_v4;
    m4rm_pkg::t_pair_mat r_pair;
    m4rm_pkg::t_sum_row  r_sum;
    logic                adv3;
    logic                adv4;

    assign adv4    = !r_v4 || i_ready;
    assign adv3    = !r_v3 || adv4;
    assign o_ready = adv3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv3) begin
                r_v3 <= i_valid;
            end
            if (adv4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3 && i_valid) begin
            for (int j = 0; j < m4rm_pkg::N; j++) begin
                r_pair[j][0] <= m4rm_pkg::PAIR_W'($signed(i_prod[j][0]))
                              + m4rm_pkg::PAIR_W'($signed(i_prod[j][1]));
                r_pair[j][1] <= m4rm_pkg::PAIR_W'($signed(i_prod[j][2]))
                              + m4rm_pkg::PAIR_W'($signed(i_prod[j][3]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv4 && r_v3) begin
            for (int j = 0; j < m4rm_pkg::N; j++) begin
                r_sum[j] <= m4rm_pkg::SUM_W'($signed(r_pair[j][0]))
                          + m4rm_pkg::SUM_W'($signed(r_pair[j][1]));
            end
        end
    end

    assign o_valid = r_v4;
    assign o_sum   = r_sum;

endmodule

`default_nettype wire

[rtl/m4rm_sat.sv]
// Stage 5: floor shift by the fraction width, clamp to 32 bits, hold the result.
// Depends on m4rm_pkg.
`default_nettype none

module m4rm_sat #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire m4rm_pkg::t_sum_row i_sum,
    output logic                    o_ready,
    output logic                    o_valid,
    output m4rm_pkg::t_row          o_prod,
    output logic                    o_saturated,
    input  wire logic               i_ready
);

    localparam int unsigned TOP_W = m4rm_pkg::SUM_W - m4rm_pkg::ELEM_W + 1;

    logic               r_v5;
    m4rm_pkg::t_row     r_prod;
    logic               r_sat;
    m4rm_pkg::t_row     n_prod;
    logic               n_sat;
    m4rm_pkg::t_sum_row sh;
    logic               adv5;

    assign adv5    = !r_v5 || i_ready;
    assign o_ready = adv5;

    always_comb begin
        n_sat = 1'b0;
        for (int j = 0; j < m4rm_pkg::N; j++) begin
            sh[j] = $signed(i_sum[j]) >>> FRAC_BITS;
            if (!sh[j][m4rm_pkg::SUM_W-1]
                && (|sh[j][m4rm_pkg::SUM_W-1 -: TOP_W])) begin
                n_prod[j] = m4rm_pkg::Q_MAX;
                n_sat     = 1'b1;
            end else if (sh[j][m4rm_pkg::SUM_W-1]
                         && !(&sh[j][m4rm_pkg::SUM_W-1 -: TOP_W])) begin
                n_prod[j] = m4rm_pkg::Q_MIN;
                n_sat     = 1'b1;
            end else begin
                n_prod[j] = sh[j][m4rm_pkg::ELEM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (adv5) begin
            r_v5 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv5 && i_valid) begin
            r_prod <= n_prod;
            r_sat  <= n_sat;
        end
    end

    assign o_valid     = r_v5;
    assign o_prod      = r_prod;
    assign o_saturated = r_sat;

endmodule

`default_nettype wire

[rtl/matrix4x4_row_multiply.sv]
// Top level of the 4x4 row multiplier in signed fixed point.
// Depends on m4rm_pkg, both channel interfaces, the stage modules and the assert header.
//
//   channel  dir  beat contents
//   i_req    in   req_type, row_index, elem0..elem3
//   o_res    out  prod0..prod3, saturated
//
// One beat per cycle while the output is not stalled; a multiply beat's row passes through
// the five register stages (capture, multiply, two adds, clamp) before it is valid.
// A load beat writes its right-matrix row at the edge that takes it; the next beat
// may already use it. Reset clears only the stage valid bits, not the matrix.
// A stalled output holds; empty stages absorb it until all five are full.
`default_nettype none

module matrix4x4_row_multiply #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    m4rm_req_if.sink    i_req,
    m4rm_res_if.source  o_res
);

`include "matrix4x4_row_multiply_assert.svh"

    m4rm_pkg::t_row      in_row;
    m4rm_pkg::t_mat      mat;
    m4rm_pkg::t_prod_mat prod;
    m4rm_pkg::t_sum_row  sum;
    m4rm_pkg::t_row      res_row;
    logic                in_ready;
    logic                in_take;
    logic                mul_valid;
    logic                mul_out_valid;
    logic                sum_ready;
    logic                sum_out_valid;
    logic                sat_ready;

    assign in_row[0] = i_req.elem0;
    assign in_row[1] = i_req.elem1;
    assign in_row[2] = i_req.elem2;
    assign in_row[3] = i_req.elem3;

    assign i_req.ready = in_ready;
    assign in_take     = i_req.valid && in_ready;
    assign mul_valid   = i_req.valid && (i_req.req_type == m4rm_pkg::REQ_MUL);

    m4rm_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (in_take && (i_req.req_type == m4rm_pkg::REQ_LOAD)),
        .i_wr_row  (i_req.row_index),
        .i_wr_data (in_row),
        .o_mat     (mat)
    );

    m4rm_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mul_valid),
        .i_row   (in_row),
        .o_ready (in_ready),
        .i_mat   (mat),
        .o_valid (mul_out_valid),
        .o_prod  (prod),
        .i_ready (sum_ready)
    );

    m4rm_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mul_out_valid),
        .i_prod  (prod),
        .o_ready (sum_ready),
        .o_valid (sum_out_valid),
        .o_sum   (sum),
        .i_ready (sat_ready)
    );

    m4rm_sat #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sat (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (sum_out_valid),
        .i_sum       (sum),
        .o_ready     (sat_ready),
        .o_valid     (o_res.valid),
        .o_prod      (res_row),
        .o_saturated (o_res.saturated),
        .i_ready     (o_res.ready)
    );

    assign o_res.prod0 = res_row[0];
    assign o_res.prod1 = res_row[1];
    assign o_res.prod2 = res_row[2];
    assign o_res.prod3 = res_row[3];

    // input backpressure only when every stage is full and the output is stalled
    `M4RM_ASSERT_NOW(a_ready_low_full, i_clk, i_rst_n, !in_ready,
        o_res.valid && !o_res.ready && sat_ready == 1'b0 && sum_ready == 1'b0,
        "input stalled while the pipeline has room")

    // a clamped row carries at least one rail value
    `M4RM_ASSERT_NOW(a_sat_rail, i_clk, i_rst_n, o_res.valid && o_res.saturated,
        o_res.prod0 == $signed(m4rm_pkg::Q_MAX) || o_res.prod0 == $signed(m4rm_pkg::Q_MIN) ||
        o_res.prod1 == $signed(m4rm_pkg::Q_MAX) || o_res.prod1 == $signed(m4rm_pkg::Q_MIN) ||
        o_res.prod2 == $signed(m4rm_pkg::Q_MAX) || o_res.prod2 == $signed(m4rm_pkg::Q_MIN) ||
        o_res.prod3 == $signed(m4rm_pkg::Q_MAX) || o_res.prod3 == $signed(m4rm_pkg::Q_MIN),
        "saturated flag set without a clamped element")

    // hold a stalled result beat unchanged
    `M4RM_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n,
        o_res.valid && !o_res.ready,
        o_res.valid && $stable(o_res.prod0) && $stable(o_res.prod1) &&
        $stable(o_res.prod2) && $stable(o_res.prod3) && $stable(o_res.saturated),
        "stalled result beat changed")

endmodule

`default_nettype wire
